// ----- sv/rgbhsv_pkg.sv -----
package rgbhsv_pkg;

  // Pixel and result field widths
  localparam int CH_W  = 8;
  localparam int HUE_W = 15;
  localparam int SAT_W = 13;

  // Signed sector numerator and its magnitude (largest magnitude is 5 * 255)
  localparam int NUM_W   = 12;
  localparam int MAG_W   = 11;
  localparam int MAX_NUM = 5 * 255;

  // Hue geometry in degrees
  localparam int HUE_SECTOR_DEG = 60;
  localparam int HUE_FULL_DEG   = 360;
  localparam int HUE_TOP_DEG    = 300;

  // Width of the hue dividend: sector unit times the numerator magnitude
  function automatic int hue_dvd_w(input int hfb);
    return $clog2((HUE_SECTOR_DEG << hfb) * MAX_NUM + 1);
  endfunction

  // Width of the hue quotient before the negative wrap
  function automatic int hue_quo_w(input int hfb);
    return $clog2((HUE_TOP_DEG << hfb) + 1);
  endfunction

  // Width of the saturation dividend: delta scaled up by the fraction bits
  function automatic int sat_dvd_w(input int sfb);
    return CH_W + sfb;
  endfunction

  // Saturation quotient reaches exactly 1.0, so one bit above the fraction
  function automatic int sat_quo_w(input int sfb);
    return sfb + 1;
  endfunction

  // Number of divider cells: one quotient bit of each divide per cell
  function automatic int step_cnt(input int hfb, input int sfb);
    return (hue_quo_w(hfb) > sat_quo_w(sfb)) ? hue_quo_w(hfb) : sat_quo_w(sfb);
  endfunction

endpackage

// ----- sv/rgbhsv_front.sv -----
module rgbhsv_front
  import rgbhsv_pkg::*;
#(
  parameter int HUE_FRAC_BITS = 6,
  parameter int SAT_FRAC_BITS = 12,
  localparam int HD_W = hue_dvd_w(HUE_FRAC_BITS),
  localparam int SD_W = sat_dvd_w(SAT_FRAC_BITS)
) (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            up_valid,
  output logic            up_ready,
  input  logic [CH_W-1:0] red,
  input  logic [CH_W-1:0] green,
  input  logic [CH_W-1:0] blue,
  output logic            dn_valid,
  input  logic            dn_ready,
  output logic [HD_W-1:0] dn_hue_dvd,
  output logic [SD_W-1:0] dn_sat_dvd,
  output logic [CH_W-1:0] dn_delta,
  output logic [CH_W-1:0] dn_hi,
  output logic            dn_neg
);

  localparam logic [HD_W-1:0] HUE_UNIT = HD_W'(HUE_SECTOR_DEG << HUE_FRAC_BITS);

  logic                    a_valid_r;
  logic [CH_W-1:0]         a_hi_r;
  logic [CH_W-1:0]         a_delta_r;
  logic [MAG_W-1:0]        a_mag_r;
  logic                    a_neg_r;
  logic                    b_valid_r;
  logic [HD_W-1:0]         b_hue_dvd_r;
  logic [SD_W-1:0]         b_sat_dvd_r;
  logic [CH_W-1:0]         b_delta_r;
  logic [CH_W-1:0]         b_hi_r;
  logic                    b_neg_r;
  logic                    a_ready;
  logic                    b_ready;
  logic [CH_W-1:0]         hi;
  logic [CH_W-1:0]         lo;
  logic [CH_W-1:0]         delta;
  logic signed [NUM_W-1:0] num;
  logic signed [NUM_W-1:0] num_abs;

  // Find max, min and the sector numerator; red wins ties, then green
  always_comb begin
    hi = (red > green) ? red : green;
    lo = (red < green) ? red : green;
    if (blue > hi) begin
      hi = blue;
    end
    if (blue < lo) begin
      lo = blue;
    end
    delta = hi - lo;
    if (red >= hi) begin
      num = $signed(NUM_W'(green)) - $signed(NUM_W'(blue));
    end else if (green >= hi) begin
      num = $signed(NUM_W'(delta) << 1) + $signed(NUM_W'(blue)) - $signed(NUM_W'(red));
    end else begin
      num = $signed(NUM_W'(delta) << 2) + $signed(NUM_W'(red)) - $signed(NUM_W'(green));
    end
    num_abs = num[NUM_W-1] ? -num : num;
  end

  // Advance each stage when it is empty or its successor takes the request
  assign b_ready  = !b_valid_r || dn_ready;
  assign a_ready  = !a_valid_r || b_ready;
  assign up_ready = a_ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      a_valid_r <= 1'b0;
      b_valid_r <= 1'b0;
    end else begin
      if (a_ready) begin
        a_valid_r <= up_valid;
      end
      if (b_ready) begin
        b_valid_r <= a_valid_r;
      end
    end
  end

  // Capture extremes and the numerator magnitude
  always_ff @(posedge clk) begin
    if (up_valid && a_ready) begin
      a_hi_r    <= hi;
      a_delta_r <= delta;
      a_mag_r   <= num_abs[MAG_W-1:0];
      a_neg_r   <= num[NUM_W-1];
    end
  end

  // Scale both dividends
  always_ff @(posedge clk) begin
    if (a_valid_r && b_ready) begin
      b_hue_dvd_r <= HUE_UNIT * HD_W'(a_mag_r);
      b_sat_dvd_r <= SD_W'(a_delta_r) << SAT_FRAC_BITS;
      b_delta_r   <= a_delta_r;
      b_hi_r      <= a_hi_r;
      b_neg_r     <= a_neg_r;
    end
  end

  assign dn_valid   = b_valid_r;
  assign dn_hue_dvd = b_hue_dvd_r;
  assign dn_sat_dvd = b_sat_dvd_r;
  assign dn_delta   = b_delta_r;
  assign dn_hi      = b_hi_r;
  assign dn_neg     = b_neg_r;

endmodule

// ----- sv/rgbhsv_div_cell.sv -----
module rgbhsv_div_cell
  import rgbhsv_pkg::*;
#(
  parameter int HUE_FRAC_BITS = 6,
  parameter int SAT_FRAC_BITS = 12,
  parameter int BIT_POS       = 0,
  localparam int HD_W = hue_dvd_w(HUE_FRAC_BITS),
  localparam int SD_W = sat_dvd_w(SAT_FRAC_BITS),
  localparam int HQ_W = hue_quo_w(HUE_FRAC_BITS),
  localparam int SQ_W = sat_quo_w(SAT_FRAC_BITS)
) (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            up_valid,
  output logic            up_ready,
  input  logic [HD_W-1:0] up_hue_rem,
  input  logic [SD_W-1:0] up_sat_rem,
  input  logic [HQ_W-1:0] up_hue_quo,
  input  logic [SQ_W-1:0] up_sat_quo,
  input  logic [CH_W-1:0] up_delta,
  input  logic [CH_W-1:0] up_hi,
  input  logic            up_neg,
  output logic            dn_valid,
  input  logic            dn_ready,
  output logic [HD_W-1:0] dn_hue_rem,
  output logic [SD_W-1:0] dn_sat_rem,
  output logic [HQ_W-1:0] dn_hue_quo,
  output logic [SQ_W-1:0] dn_sat_quo,
  output logic [CH_W-1:0] dn_delta,
  output logic [CH_W-1:0] dn_hi,
  output logic            dn_neg
);

  logic            valid_r;
  logic [HD_W-1:0] hue_rem_r;
  logic [SD_W-1:0] sat_rem_r;
  logic [HQ_W-1:0] hue_quo_r;
  logic [SQ_W-1:0] sat_quo_r;
  logic [CH_W-1:0] delta_r;
  logic [CH_W-1:0] hi_r;
  logic            neg_r;
  logic [HD_W-1:0] hue_rem_nxt;
  logic [SD_W-1:0] sat_rem_nxt;
  logic [HQ_W-1:0] hue_quo_nxt;
  logic [SQ_W-1:0] sat_quo_nxt;

  // Hue divide: try to subtract delta at this quotient bit
  if (BIT_POS < HQ_W) begin : g_hue
    localparam int HR_W = HD_W - BIT_POS;
    always_comb begin
      if (up_hue_rem[HD_W-1:BIT_POS] >= HR_W'(up_delta)) begin
        hue_rem_nxt = up_hue_rem - (HD_W'(up_delta) << BIT_POS);
        hue_quo_nxt = up_hue_quo | (HQ_W'(1) << BIT_POS);
      end else begin
        hue_rem_nxt = up_hue_rem;
        hue_quo_nxt = up_hue_quo;
      end
    end
  end else begin : g_hue_idle
    assign hue_rem_nxt = up_hue_rem;
    assign hue_quo_nxt = up_hue_quo;
  end

  // Saturation divide: try to subtract the max at this quotient bit
  if (BIT_POS < SQ_W) begin : g_sat
    localparam int SR_W = SD_W - BIT_POS;
    always_comb begin
      if (up_sat_rem[SD_W-1:BIT_POS] >= SR_W'(up_hi)) begin
        sat_rem_nxt = up_sat_rem - (SD_W'(up_hi) << BIT_POS);
        sat_quo_nxt = up_sat_quo | (SQ_W'(1) << BIT_POS);
      end else begin
        sat_rem_nxt = up_sat_rem;
        sat_quo_nxt = up_sat_quo;
      end
    end
  end else begin : g_sat_idle
    assign sat_rem_nxt = up_sat_rem;
    assign sat_quo_nxt = up_sat_quo;
  end

  assign up_ready = !valid_r || dn_ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else if (up_ready) begin
      valid_r <= up_valid;
    end
  end

  // Hand the partial results to the next cell
  always_ff @(posedge clk) begin
    if (up_valid && up_ready) begin
      hue_rem_r <= hue_rem_nxt;
      sat_rem_r <= sat_rem_nxt;
      hue_quo_r <= hue_quo_nxt;
      sat_quo_r <= sat_quo_nxt;
      delta_r   <= up_delta;
      hi_r      <= up_hi;
      neg_r     <= up_neg;
    end
  end

  assign dn_valid   = valid_r;
  assign dn_hue_rem = hue_rem_r;
  assign dn_sat_rem = sat_rem_r;
  assign dn_hue_quo = hue_quo_r;
  assign dn_sat_quo = sat_quo_r;
  assign dn_delta   = delta_r;
  assign dn_hi      = hi_r;
  assign dn_neg     = neg_r;

endmodule

// ----- sv/rgb_to_hsv_converter.sv -----
// Channel   Direction  Handshake           Payload
// in_       input      in_valid/in_stall   in_red, in_green, in_blue (8 bits each)
// out_      output     out_valid/out_stall out_hue (15), out_saturation (13), out_value (8)
//
// One pixel is taken every clock while the output is not stalled.
// The path has two front stages, N divider cells (one quotient bit
// of each divide per cell, N = 15 at the default fraction bits) and the output register.
// Reset clears only the valid bits of the stages; the pipeline then accepts at once.
// A stall on the output backs up stage by stage; empty stages keep filling.
module rgb_to_hsv_converter
  import rgbhsv_pkg::*;
#(
  parameter int HUE_FRAC_BITS = 6,
  parameter int SAT_FRAC_BITS = 12
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             in_valid,
  output logic             in_stall,
  input  logic [CH_W-1:0]  in_red,
  input  logic [CH_W-1:0]  in_green,
  input  logic [CH_W-1:0]  in_blue,
  output logic             out_valid,
  input  logic             out_stall,
  output logic [HUE_W-1:0] out_hue,
  output logic [SAT_W-1:0] out_saturation,
  output logic [CH_W-1:0]  out_value
);

  localparam int HD_W   = hue_dvd_w(HUE_FRAC_BITS);
  localparam int SD_W   = sat_dvd_w(SAT_FRAC_BITS);
  localparam int HQ_W   = hue_quo_w(HUE_FRAC_BITS);
  localparam int SQ_W   = sat_quo_w(SAT_FRAC_BITS);
  localparam int N      = step_cnt(HUE_FRAC_BITS, SAT_FRAC_BITS);
  localparam int FULL   = HUE_FULL_DEG << HUE_FRAC_BITS;
  localparam int FULL_W = $clog2(FULL + 1);

  logic            front_ready;
  logic            chain_valid [N+1];
  logic            chain_ready [N+1];
  logic [HD_W-1:0] chain_hue_rem [N+1];
  logic [SD_W-1:0] chain_sat_rem [N+1];
  logic [HQ_W-1:0] chain_hue_quo [N+1];
  logic [SQ_W-1:0] chain_sat_quo [N+1];
  logic [CH_W-1:0] chain_delta [N+1];
  logic [CH_W-1:0] chain_hi [N+1];
  logic            chain_neg [N+1];

  logic              out_valid_r;
  logic [HUE_W-1:0]  out_hue_r;
  logic [SAT_W-1:0]  out_sat_r;
  logic [CH_W-1:0]   out_val_r;
  logic [FULL_W-1:0] hue_full;
  logic [HUE_W-1:0]  out_hue_nxt;
  logic [SAT_W-1:0]  out_sat_nxt;
  logic              out_ready;

  assign in_stall = !front_ready;

  // Extremes, sector numerator and scaled dividends
  rgbhsv_front #(
    .HUE_FRAC_BITS(HUE_FRAC_BITS),
    .SAT_FRAC_BITS(SAT_FRAC_BITS)
  ) u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .up_valid  (in_valid),
    .up_ready  (front_ready),
    .red       (in_red),
    .green     (in_green),
    .blue      (in_blue),
    .dn_valid  (chain_valid[0]),
    .dn_ready  (chain_ready[0]),
    .dn_hue_dvd(chain_hue_rem[0]),
    .dn_sat_dvd(chain_sat_rem[0]),
    .dn_delta  (chain_delta[0]),
    .dn_hi     (chain_hi[0]),
    .dn_neg    (chain_neg[0])
  );

  assign chain_hue_quo[0] = '0;
  assign chain_sat_quo[0] = '0;

  // Divider chain, most significant quotient bit first
  for (genvar k = 0; k < N; k++) begin : g_cell
    rgbhsv_div_cell #(
      .HUE_FRAC_BITS(HUE_FRAC_BITS),
      .SAT_FRAC_BITS(SAT_FRAC_BITS),
      .BIT_POS      (N - 1 - k)
    ) u_cell (
      .clk       (clk),
      .rst_n     (rst_n),
      .up_valid  (chain_valid[k]),
      .up_ready  (chain_ready[k]),
      .up_hue_rem(chain_hue_rem[k]),
      .up_sat_rem(chain_sat_rem[k]),
      .up_hue_quo(chain_hue_quo[k]),
      .up_sat_quo(chain_sat_quo[k]),
      .up_delta  (chain_delta[k]),
      .up_hi     (chain_hi[k]),
      .up_neg    (chain_neg[k]),
      .dn_valid  (chain_valid[k+1]),
      .dn_ready  (chain_ready[k+1]),
      .dn_hue_rem(chain_hue_rem[k+1]),
      .dn_sat_rem(chain_sat_rem[k+1]),
      .dn_hue_quo(chain_hue_quo[k+1]),
      .dn_sat_quo(chain_sat_quo[k+1]),
      .dn_delta  (chain_delta[k+1]),
      .dn_hi     (chain_hi[k+1]),
      .dn_neg    (chain_neg[k+1])
    );
  end

  // Zero grey pixels, wrap negative hue into the full circle
  always_comb begin
    if (chain_delta[N] == '0) begin
      hue_full    = '0;
      out_sat_nxt = '0;
    end else begin
      out_sat_nxt = SAT_W'(chain_sat_quo[N]);
      if (chain_neg[N] && (chain_hue_quo[N] != '0)) begin
        hue_full = FULL_W'(FULL) - FULL_W'(chain_hue_quo[N]);
      end else begin
        hue_full = FULL_W'(chain_hue_quo[N]);
      end
    end
    out_hue_nxt = HUE_W'(hue_full);
  end

  assign out_ready    = !out_valid_r || !out_stall;
  assign chain_ready[N] = out_ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (out_ready) begin
      out_valid_r <= chain_valid[N];
    end
  end

  // Hold the finished request until it is taken
  always_ff @(posedge clk) begin
    if (chain_valid[N] && out_ready) begin
      out_hue_r <= out_hue_nxt;
      out_sat_r <= out_sat_nxt;
      out_val_r <= chain_hi[N];
    end
  end

  assign out_valid      = out_valid_r;
  assign out_hue        = out_hue_r;
  assign out_saturation = out_sat_r;
  assign out_value      = out_val_r;

endmodule

// ----- sv/rgbhsv_checker.sv -----
module rgbhsv_checker
  import rgbhsv_pkg::*;
#(
  parameter int SAT_FRAC_BITS = 12
) (
  input logic             clk,
  input logic             rst_n,
  input logic             out_valid,
  input logic             out_stall,
  input logic [HUE_W-1:0] out_hue,
  input logic [SAT_W-1:0] out_saturation,
  input logic [CH_W-1:0]  out_value
);

  // Stalled result stays offered
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid)
    else $error("result dropped while stalled");

  // Stalled result keeps its payload
  a_out_stable: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> $stable(out_hue) && $stable(out_saturation)
      && $stable(out_value))
    else $error("result changed while stalled");

  // Black has no hue and no saturation
  a_black: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && (out_value == '0) |-> (out_hue == '0) && (out_saturation == '0))
    else $error("black pixel with hue or saturation");

  // Saturation never exceeds one, and is zero only for grey
  if (SAT_FRAC_BITS >= CH_W && SAT_FRAC_BITS < SAT_W) begin : g_sat
    localparam logic [SAT_W-1:0] SAT_ONE = SAT_W'(1) << SAT_FRAC_BITS;

    a_sat_range: assert property (@(posedge clk) disable iff (!rst_n)
      out_valid |-> out_saturation <= SAT_ONE)
      else $error("saturation above one");

    a_grey: assert property (@(posedge clk) disable iff (!rst_n)
      out_valid && (out_saturation == '0) |-> (out_hue == '0))
      else $error("unsaturated pixel with nonzero hue");
  end

endmodule

bind rgb_to_hsv_converter rgbhsv_checker #(
  .SAT_FRAC_BITS(SAT_FRAC_BITS)
) u_rgbhsv_checker (.*);
